[sv/kit_pkg.sv]
package kit_pkg;

	localparam int TABLE_DEPTH_DEF = 64;

	localparam int KIND_W    = 2;
	localparam int IDX_W     = 32;
	localparam int TS_W      = 32;
	localparam int LAT_W     = 31;
	localparam int GROUP_W   = 16;
	localparam int ENTRY_W   = 7;

	localparam logic [KIND_W-1:0] KIND_FRAME  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EXPIRE = 2'd2;

	localparam logic [LAT_W-1:0]   LATENCY_RESET = 31'd3000;
	localparam logic [GROUP_W-1:0] GROUP_MAX     = 16'hFFFF;

	// controller -> datapath
	typedef struct packed {
		logic accept;  // input beat taken this cycle
		logic walk;    // table walk in progress
		logic load;    // move result into the output register
	} kit_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_walk;    // input beat needs a table walk
		logic walk_done;  // walk finishes this cycle
		logic out_free;   // output register can take a result
	} kit_sts_t;

endpackage

[sv/kit_ctrl.sv]
module kit_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  kit_pkg::kit_sts_t sts,
	output kit_pkg::kit_cmd_t cmd
);
	import kit_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_LOAD = 3'b100
	} state_t;

	state_t state_q, state_d;

	assign in_stall   = (state_q != ST_IDLE);
	assign cmd.accept = in_valid && (state_q == ST_IDLE);
	assign cmd.walk   = (state_q == ST_WALK);
	assign cmd.load   = (state_q == ST_LOAD) && sts.out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept) begin
					state_d = sts.in_walk ? ST_WALK : ST_LOAD;
				end
			end
			ST_WALK: begin
				if (sts.walk_done) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[sv/kit_dp.sv]
module kit_dp #(
	parameter int TABLE_DEPTH = kit_pkg::TABLE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  kit_pkg::kit_cmd_t                  cmd,
	output kit_pkg::kit_sts_t                  sts,
	input  logic [kit_pkg::KIND_W-1:0]         kind,
	input  logic [kit_pkg::IDX_W-1:0]          frame_index,
	input  logic [kit_pkg::TS_W-1:0]           frame_timestamp,
	input  logic                               is_key_frame,
	input  logic [kit_pkg::IDX_W-1:0]          expire_index,
	input  logic                               cfg_we,
	input  logic [kit_pkg::LAT_W-1:0]          cfg_wdata,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               found_valid,
	output logic [kit_pkg::IDX_W-1:0]          found_index,
	output logic signed [kit_pkg::TS_W-1:0]    found_latency,
	output logic [kit_pkg::GROUP_W-1:0]        longest_group,
	output logic [kit_pkg::ENTRY_W-1:0]        entry_count,
	output logic                               dropped_oldest
);
	import kit_pkg::*;

	localparam int PW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = IDX_W + TS_W;

	// ring slot of an offset from the oldest entry; head + offset < 2 * depth
	function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] head,
			input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(head) + (CW+1)'(off);
		if (sum >= (CW+1)'(TABLE_DEPTH)) begin
			sum = sum - (CW+1)'(TABLE_DEPTH);
		end
		return PW'(sum);
	endfunction

	logic [EW-1:0]      mem [TABLE_DEPTH];
	logic [EW-1:0]      rd_data_s1;
	logic               rd_vld_s1;

	logic [LAT_W-1:0]   tl_q;
	logic [PW-1:0]      head_q;
	logic [CW-1:0]      count_q;
	logic [TS_W-1:0]    newest_q;
	logic [GROUP_W-1:0] group_q;
	logic [GROUP_W-1:0] max_group_q;
	logic [KIND_W-1:0]  kind_q;
	logic [IDX_W-1:0]   bound_q;
	logic [CW-1:0]      iss_q;
	logic [CW-1:0]      kept_q;
	logic               fvalid_q;
	logic [IDX_W-1:0]   findex_q;
	logic [TS_W-1:0]    flat_q;
	logic               dropped_q;

	logic               out_valid_q;
	logic               o_fvalid_q;
	logic [IDX_W-1:0]   o_findex_q;
	logic [TS_W-1:0]    o_flat_q;
	logic [GROUP_W-1:0] o_group_q;
	logic [ENTRY_W-1:0] o_count_q;
	logic               o_dropped_q;

	logic               is_frame;
	logic               full;
	logic               frame_wr;
	logic               q_walk;
	logic [IDX_W-1:0]   rd_index;
	logic [TS_W-1:0]    rd_time;
	logic [TS_W-1:0]    age;
	logic               pass;
	logic               keep;
	logic               issue;
	logic [CW-1:0]      rd_off;
	logic [PW-1:0]      rd_slot;
	logic               wr_en;
	logic [PW-1:0]      wr_slot;
	logic [EW-1:0]      wr_data;

	assign is_frame = (kind == KIND_FRAME);
	assign full     = (count_q == CW'(TABLE_DEPTH));
	assign frame_wr = cmd.accept && is_frame && is_key_frame;
	assign q_walk   = (kind_q == KIND_QUERY);

	assign rd_index = rd_data_s1[EW-1:TS_W];
	assign rd_time  = rd_data_s1[TS_W-1:0];
	assign age      = newest_q - rd_time;
	assign pass     = $signed(age) < $signed({1'b0, tl_q});
	assign keep     = rd_vld_s1 && !q_walk && (rd_index > bound_q);

	assign sts.in_walk   = (kind == KIND_QUERY) || (kind == KIND_EXPIRE);
	assign sts.walk_done = cmd.walk && ((rd_vld_s1 && q_walk && !pass) ||
			(iss_q == '0 && !rd_vld_s1));
	assign sts.out_free  = !out_valid_q || !out_stall;

	// query walks newest to oldest, expiry oldest to newest
	assign issue   = cmd.walk && (iss_q != '0) && !sts.walk_done;
	assign rd_off  = q_walk ? (iss_q - CW'(1)) : (count_q - iss_q);
	assign rd_slot = slot_of(head_q, rd_off);

	always_comb begin
		wr_en   = frame_wr || keep;
		wr_slot = slot_of(head_q, kept_q);
		wr_data = rd_data_s1;
		if (frame_wr) begin
			wr_slot = full ? head_q : slot_of(head_q, count_q);
			wr_data = {frame_index, frame_timestamp};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_slot] <= wr_data;
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_q        <= LATENCY_RESET;
			head_q      <= '0;
			count_q     <= '0;
			newest_q    <= '0;
			group_q     <= '0;
			max_group_q <= '0;
			kind_q      <= KIND_FRAME;
			iss_q       <= '0;
			kept_q      <= '0;
			rd_vld_s1   <= 1'b0;
			fvalid_q    <= 1'b0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tl_q <= cfg_wdata;
			end
			rd_vld_s1 <= issue;
			if (cmd.accept) begin
				kind_q    <= kind;
				iss_q     <= count_q;
				kept_q    <= '0;
				fvalid_q  <= 1'b0;
				dropped_q <= 1'b0;
				if (is_frame) begin
					newest_q <= frame_timestamp;
					if (is_key_frame) begin
						if (full) begin
							head_q    <= (head_q == PW'(TABLE_DEPTH - 1)) ? '0 :
									head_q + PW'(1);
							dropped_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
						end
						if (group_q > max_group_q) begin
							max_group_q <= group_q;
						end
						group_q <= GROUP_W'(1);
					end else if (group_q != GROUP_MAX) begin
						group_q <= group_q + GROUP_W'(1);
					end
				end
			end
			if (issue) begin
				iss_q <= iss_q - CW'(1);
			end
			if (rd_vld_s1 && q_walk && pass && cmd.walk) begin
				fvalid_q <= 1'b1;
			end
			if (keep) begin
				kept_q <= kept_q + CW'(1);
			end
			if (sts.walk_done && !q_walk) begin
				count_q <= kept_q;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			bound_q  <= expire_index;
			findex_q <= '0;
			flat_q   <= '0;
		end
		if (rd_vld_s1 && q_walk && pass && cmd.walk) begin
			findex_q <= rd_index;
			flat_q   <= age;
		end
		if (cmd.load) begin
			o_fvalid_q  <= fvalid_q;
			o_findex_q  <= findex_q;
			o_flat_q    <= flat_q;
			o_group_q   <= max_group_q;
			o_count_q   <= ENTRY_W'(count_q);
			o_dropped_q <= dropped_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign found_valid    = o_fvalid_q;
	assign found_index    = o_findex_q;
	assign found_latency  = $signed(o_flat_q);
	assign longest_group  = o_group_q;
	assign entry_count    = o_count_q;
	assign dropped_oldest = o_dropped_q;

endmodule

[sv/keyframe_index_table.sv]
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall | kind, frame_index, frame_timestamp,
//         |           |                     | is_key_frame, expire_index
// out     | output    | out_valid/out_stall | found_valid, found_index, found_latency,
//         |           |                     | longest_group, entry_count, dropped_oldest
// cfg     | input     | cfg_we              | cfg_wdata (target_latency)
//
// Frame and unused-kind beats skip the walk: idle, then load into the output register.
// Query and expiry beats walk the entry RAM through its single read port,
// one entry per cycle, before the result is loaded.
// One beat in flight at a time; a new input beat is taken while the previous
// result still waits in the output register under out_stall.
// arst_n clears all control state; the entry RAM has no reset.
module keyframe_index_table #(
	parameter int TABLE_DEPTH = kit_pkg::TABLE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input beat
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [kit_pkg::KIND_W-1:0]         kind,
	input  logic [kit_pkg::IDX_W-1:0]          frame_index,
	input  logic [kit_pkg::TS_W-1:0]           frame_timestamp,
	input  logic                               is_key_frame,
	input  logic [kit_pkg::IDX_W-1:0]          expire_index,
	// latency bound register
	input  logic                               cfg_we,
	input  logic [kit_pkg::LAT_W-1:0]          cfg_wdata,
	// result beat
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               found_valid,
	output logic [kit_pkg::IDX_W-1:0]          found_index,
	output logic signed [kit_pkg::TS_W-1:0]    found_latency,
	output logic [kit_pkg::GROUP_W-1:0]        longest_group,
	output logic [kit_pkg::ENTRY_W-1:0]        entry_count,
	output logic                               dropped_oldest
);
	import kit_pkg::*;

	kit_cmd_t cmd;
	kit_sts_t sts;

	// sequencer: idle -> (walk) -> load result
	kit_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// ring RAM, ring pointers, group tracking, search/compaction and result regs
	kit_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.kind            (kind),
		.frame_index     (frame_index),
		.frame_timestamp (frame_timestamp),
		.is_key_frame    (is_key_frame),
		.expire_index    (expire_index),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.found_valid     (found_valid),
		.found_index     (found_index),
		.found_latency   (found_latency),
		.longest_group   (longest_group),
		.entry_count     (entry_count),
		.dropped_oldest  (dropped_oldest)
	);

endmodule
